// File: rtl/core/pinhole_point_projector_macros.svh
// Assertion macros for the point projector.
`ifndef PINHOLE_POINT_PROJECTOR_MACROS_SVH
`define PINHOLE_POINT_PROJECTOR_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define PPP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define PPP_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define PPP_ASSERT(lbl, clk, rst, prop, msg)
`define PPP_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// File: rtl/core/ppp_pkg.sv
package ppp_pkg;

  // Image geometry and intrinsics
  localparam int IMG_W = 1024;
  localparam int IMG_H = 640;
  localparam int QUO_W = 10;

  // Datapath widths
  localparam int DIFF_W = 33;
  localparam int ENT_W  = 33;
  localparam int TERM_W = 52;
  localparam int CAM_W  = 54;
  localparam int NUM_W  = 66;
  localparam int DEN_W  = 55;
  localparam int DIV_LAT = QUO_W + 1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ROT_W   = 3'd0,
    REG_ROT_X   = 3'd1,
    REG_ROT_Y   = 3'd2,
    REG_ROT_Z   = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6
  } cfg_reg_t;

  // floor(2*a*b) in Q2.30: floor(a*b / 2^29)
  function automatic logic signed [34:0] twice(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:29];
  endfunction

  // Clamp a rotation entry to +/- 2^31
  function automatic logic signed [ENT_W-1:0] sat_entry(input logic signed [36:0] v);
    logic signed [36:0] lim;
    lim = 37'sd2147483648;
    if (v > lim) return 33'sd2147483648;
    else if (v < -lim) return -33'sd2147483648;
    else return v[ENT_W-1:0];
  endfunction

  // Round level*255 / 2^16, saturate at 255
  function automatic logic [7:0] color_byte(input logic [16:0] level);
    logic [25:0] s;
    s = ({9'd0, level} << 8) - {9'd0, level} + 26'd32768;
    if (s[25:16] > 10'd255) return 8'd255;
    else return s[23:16];
  endfunction

endpackage

// File: rtl/core/ppp_div.sv
module ppp_div (
  input  logic                      clk,
  input  logic [ppp_pkg::NUM_W-1:0] num,
  input  logic [ppp_pkg::DEN_W-1:0] den,
  input  logic                      ok_in,
  output logic [ppp_pkg::QUO_W-1:0] quo,
  output logic                      ok_out
);
  import ppp_pkg::*;

  logic [NUM_W-1:0] rem [0:QUO_W];
  logic [DEN_W-1:0] dv  [0:QUO_W];
  logic [QUO_W-1:0] qb  [0:QUO_W];
  logic             ok  [0:QUO_W];

  // Enter: flag quotients that would not fit in QUO_W bits
  always_ff @(posedge clk) begin
    rem[0] <= num;
    dv[0]  <= den;
    qb[0]  <= '0;
    ok[0]  <= ok_in && (num < (NUM_W'(den) << QUO_W));
  end

  // Restoring division, one quotient bit per stage, top bit first
  always_ff @(posedge clk) begin
    for (int k = 0; k < QUO_W; k++) begin
      if (rem[k] >= (NUM_W'(dv[k]) << (QUO_W - 1 - k))) begin
        rem[k+1] <= rem[k] - (NUM_W'(dv[k]) << (QUO_W - 1 - k));
        qb[k+1]  <= qb[k] | (QUO_W'(1) << (QUO_W - 1 - k));
      end else begin
        rem[k+1] <= rem[k];
        qb[k+1]  <= qb[k];
      end
      dv[k+1] <= dv[k];
      ok[k+1] <= ok[k];
    end
  end

  assign quo    = qb[QUO_W];
  assign ok_out = ok[QUO_W];

endmodule

// File: rtl/core/pinhole_point_projector.sv
// Channel   Ports                                         Handshake
// point in  world_x/y/z, red/green/blue_level             start & !busy
// pixel out pixel_column, pixel_row, blue/green/red_byte  done, one cycle
// config    psel penable pwrite paddr pwdata prdata       APB, pready tied high
//
// One point is taken per cycle while busy is low; its pixel then passes through
// the 3 rotation/projection stages, the 11-stage quotient pipeline and the
// output register.
// After reset or a register write, busy stays high while the rotation matrix,
// built in two registered stages, settles.
// The pipeline never stalls; the receiver must take each pixel as shown.
`include "pinhole_point_projector_macros.svh"

module pinhole_point_projector (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] world_x,
  input  logic signed [31:0] world_y,
  input  logic signed [31:0] world_z,
  input  logic [16:0]        red_level,
  input  logic [16:0]        green_level,
  input  logic [16:0]        blue_level,
  output logic               done,
  output logic [9:0]         pixel_column,
  output logic [9:0]         pixel_row,
  output logic [7:0]         blue_byte,
  output logic [7:0]         green_byte,
  output logic [7:0]         red_byte,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ppp_pkg::*;

  logic signed [31:0] rot_w, rot_x, rot_y, rot_z;
  logic signed [31:0] shift_x, shift_y, shift_z;
  logic               wr;
  logic [1:0]         hold;
  logic               acc;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign busy   = (hold != 2'd0);
  assign acc    = start && !busy;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_w   <= 32'sd1073741824;
      rot_x   <= '0;
      rot_y   <= '0;
      rot_z   <= '0;
      shift_x <= '0;
      shift_y <= '0;
      shift_z <= '0;
    end else if (wr) begin
      unique case (cfg_reg_t'(paddr[4:2]))
        REG_ROT_W:   rot_w   <= pwdata;
        REG_ROT_X:   rot_x   <= pwdata;
        REG_ROT_Y:   rot_y   <= pwdata;
        REG_ROT_Z:   rot_z   <= pwdata;
        REG_SHIFT_X: shift_x <= pwdata;
        REG_SHIFT_Y: shift_y <= pwdata;
        REG_SHIFT_Z: shift_z <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (cfg_reg_t'(paddr[4:2]))
      REG_ROT_W:   prdata = rot_w;
      REG_ROT_X:   prdata = rot_x;
      REG_ROT_Y:   prdata = rot_y;
      REG_ROT_Z:   prdata = rot_z;
      REG_SHIFT_X: prdata = shift_x;
      REG_SHIFT_Y: prdata = shift_y;
      REG_SHIFT_Z: prdata = shift_z;
      default:     prdata = '0;
    endcase
  end

  // Hold off points while the matrix settles
  always_ff @(posedge clk) begin
    if (rst || wr) begin
      hold <= 2'd3;
    end else if (hold != 2'd0) begin
      hold <= hold - 2'd1;
    end
  end

  // Quaternion products
  logic signed [34:0] xx, yy, zz, xy, zw, xz, yw, yz, xw;
  always_ff @(posedge clk) begin
    xx <= twice(rot_x, rot_x);
    yy <= twice(rot_y, rot_y);
    zz <= twice(rot_z, rot_z);
    xy <= twice(rot_x, rot_y);
    zw <= twice(rot_z, rot_w);
    xz <= twice(rot_x, rot_z);
    yw <= twice(rot_y, rot_w);
    yz <= twice(rot_y, rot_z);
    xw <= twice(rot_x, rot_w);
  end

  // Rotation matrix entries
  localparam logic signed [36:0] ONE = 37'sd1073741824;
  logic signed [ENT_W-1:0] rm [0:2][0:2];
  always_ff @(posedge clk) begin
    rm[0][0] <= sat_entry(ONE - 37'(yy) - 37'(zz));
    rm[0][1] <= sat_entry(37'(xy) - 37'(zw));
    rm[0][2] <= sat_entry(37'(xz) + 37'(yw));
    rm[1][0] <= sat_entry(37'(xy) + 37'(zw));
    rm[1][1] <= sat_entry(ONE - 37'(xx) - 37'(zz));
    rm[1][2] <= sat_entry(37'(yz) - 37'(xw));
    rm[2][0] <= sat_entry(37'(xz) - 37'(yw));
    rm[2][1] <= sat_entry(37'(yz) + 37'(xw));
    rm[2][2] <= sat_entry(ONE - 37'(xx) - 37'(yy));
  end

  // Stage 1: offset from camera, color bytes
  logic                     v1;
  logic signed [DIFF_W-1:0] d [0:2];
  logic [7:0]               b1, g1, r1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= acc;
    d[0] <= DIFF_W'(world_x) - DIFF_W'(shift_x);
    d[1] <= DIFF_W'(world_y) - DIFF_W'(shift_y);
    d[2] <= DIFF_W'(world_z) - DIFF_W'(shift_z);
    b1   <= color_byte(blue_level);
    g1   <= color_byte(green_level);
    r1   <= color_byte(red_level);
  end

  // Stage 2: rotation terms floor(R[j][i]*d[j] / 2^14)
  logic                     v2;
  logic signed [TERM_W-1:0] pr [0:2][0:2];
  logic [7:0]               b2, g2, r2;
  logic signed [65:0]       prod [0:2][0:2];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i][j] = 66'(rm[j][i]) * 66'(d[j]);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pr[i][j] <= prod[i][j][TERM_W+13:14];
      end
    end
    b2 <= b1;
    g2 <= g1;
    r2 <= r1;
  end

  // Stage 3: camera-frame coordinates
  logic                    v3;
  logic signed [CAM_W-1:0] c [0:2];
  logic [7:0]              b3, g3, r3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    for (int i = 0; i < 3; i++) begin
      c[i] <= CAM_W'(pr[i][0]) + CAM_W'(pr[i][1]) + CAM_W'(pr[i][2]);
    end
    b3 <= b2;
    g3 <= g2;
    r3 <= r2;
  end

  // Form magnitudes for round-half-away division
  logic signed [64:0] ncol, nrow;
  logic [64:0]        mcol, mrow;
  logic [CAM_W-1:0]   mden;
  logic [NUM_W-1:0]   num_col, num_row;
  logic [DEN_W-1:0]   den;
  logic               ok_col, ok_row;
  always_comb begin
    ncol    = (65'(c[2]) - 65'(c[0])) <<< 9;
    nrow    = ((-65'(c[1])) <<< 9) + (65'(c[2]) <<< 8) + (65'(c[2]) <<< 6);
    mcol    = ncol[64] ? 65'(-ncol) : 65'(ncol);
    mrow    = nrow[64] ? 65'(-nrow) : 65'(nrow);
    mden    = c[2][CAM_W-1] ? CAM_W'(-c[2]) : CAM_W'(c[2]);
    num_col = {mcol, 1'b0} + NUM_W'(mden);
    num_row = {mrow, 1'b0} + NUM_W'(mden);
    den     = {mden, 1'b0};
    ok_col  = (c[2] != '0) && (ncol[64] == c[2][CAM_W-1]);
    ok_row  = (c[2] != '0) && (nrow[64] == c[2][CAM_W-1]);
  end

  logic [QUO_W-1:0] q_col, q_row;
  logic             okq_col, okq_row;

  ppp_div u_div_col (
    .clk    (clk),
    .num    (num_col),
    .den    (den),
    .ok_in  (ok_col),
    .quo    (q_col),
    .ok_out (okq_col)
  );

  ppp_div u_div_row (
    .clk    (clk),
    .num    (num_row),
    .den    (den),
    .ok_in  (ok_row),
    .quo    (q_row),
    .ok_out (okq_row)
  );

  // Carry valid and colors alongside the dividers
  logic       vline [0:DIV_LAT-1];
  logic [7:0] bl [0:DIV_LAT-1];
  logic [7:0] gl [0:DIV_LAT-1];
  logic [7:0] rl [0:DIV_LAT-1];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) vline[k] <= 1'b0;
    end else begin
      vline[0] <= v3;
      for (int k = 1; k < DIV_LAT; k++) vline[k] <= vline[k-1];
    end
    bl[0] <= b3;
    gl[0] <= g3;
    rl[0] <= r3;
    for (int k = 1; k < DIV_LAT; k++) begin
      bl[k] <= bl[k-1];
      gl[k] <= gl[k-1];
      rl[k] <= rl[k-1];
    end
  end

  // Output: drop points off the image
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vline[DIV_LAT-1] && okq_col && okq_row &&
              (q_col != '0) && ({1'b0, q_col} < 11'(IMG_W)) &&
              (q_row != '0) && ({1'b0, q_row} < 11'(IMG_H));
    end
    pixel_column <= q_col;
    pixel_row    <= q_row;
    blue_byte    <= bl[DIV_LAT-1];
    green_byte   <= gl[DIV_LAT-1];
    red_byte     <= rl[DIV_LAT-1];
  end

  `PPP_ASSERT(a_done_lat, clk, rst, done |-> $past(acc, 15), "pixel without a point")
  `PPP_ASSERT(a_wr_busy, clk, rst, wr |=> busy, "point taken right after a write")
  `PPP_NEVER(a_pix_zero, clk, rst, done && (pixel_column == 10'd0 || pixel_row == 10'd0), "pixel on border")

endmodule

// File: bench/ppp_checker.sv
`timescale 1ns / 100ps

// Scoreboard for the point projector: mirrors the pose registers, predicts
// the pixel of every accepted point and compares each emitted pixel in order.
module ppp_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] world_x,
  input  logic signed [31:0] world_y,
  input  logic signed [31:0] world_z,
  input  logic [16:0]        red_level,
  input  logic [16:0]        green_level,
  input  logic [16:0]        blue_level,
  input  logic               done,
  input  logic [9:0]         pixel_column,
  input  logic [9:0]         pixel_row,
  input  logic [7:0]         blue_byte,
  input  logic [7:0]         green_byte,
  input  logic [7:0]         red_byte,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 errors,
  output int                 pending
);
  import ppp_pkg::*;

  typedef struct packed {
    logic [9:0] col;
    logic [9:0] row;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  localparam longint UNIT_Q30  = 64'sd1073741824;
  localparam longint ENTRY_MAX = 64'sd2147483648;

  pixel_t expected_pixels[$];
  logic signed [31:0] pose [7];

  // floor(2*a*b) in Q2.30
  function automatic longint rot_term(input longint a, input longint b);
    return (a * b) >>> 29;
  endfunction

  function automatic longint clamp_entry(input longint v);
    if (v > ENTRY_MAX) return ENTRY_MAX;
    if (v < -ENTRY_MAX) return -ENTRY_MAX;
    return v;
  endfunction

  // Divide with rounding half away from zero
  function automatic longint div_nearest(input longint n, input longint d);
    longint mag, q;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    mag = (n < 0) ? -n : n;
    q = (2 * mag + d) / (2 * d);
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic [7:0] level_to_byte(input logic [16:0] level);
    int s;
    s = (int'(level) * 255 + 32768) >>> 16;
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  // Return 1 and the pixel when the point lands inside the image
  function automatic bit project_point(input logic signed [31:0] px, py, pz,
                                       input logic [16:0] rl, gl, bl,
                                       output pixel_t pix);
    longint w, x, y, z, col, row;
    longint r [3][3];
    longint d [3];
    longint c [3];
    logic signed [95:0] prod;
    w = pose[REG_ROT_W];
    x = pose[REG_ROT_X];
    y = pose[REG_ROT_Y];
    z = pose[REG_ROT_Z];
    pix = '0;
    r[0][0] = UNIT_Q30 - rot_term(y, y) - rot_term(z, z);
    r[0][1] = rot_term(x, y) - rot_term(z, w);
    r[0][2] = rot_term(x, z) + rot_term(y, w);
    r[1][0] = rot_term(x, y) + rot_term(z, w);
    r[1][1] = UNIT_Q30 - rot_term(x, x) - rot_term(z, z);
    r[1][2] = rot_term(y, z) - rot_term(x, w);
    r[2][0] = rot_term(x, z) - rot_term(y, w);
    r[2][1] = rot_term(y, z) + rot_term(x, w);
    r[2][2] = UNIT_Q30 - rot_term(x, x) - rot_term(y, y);
    d[0] = longint'(px) - longint'(pose[REG_SHIFT_X]);
    d[1] = longint'(py) - longint'(pose[REG_SHIFT_Y]);
    d[2] = longint'(pz) - longint'(pose[REG_SHIFT_Z]);
    for (int i = 0; i < 3; i++) begin
      c[i] = 0;
      for (int j = 0; j < 3; j++) begin
        prod = 96'(signed'(clamp_entry(r[j][i]))) * 96'(signed'(d[j]));
        c[i] += longint'(prod >>> 14);
      end
    end
    // drop points at zero depth
    if (c[2] == 0) return 0;
    col = div_nearest(-512 * c[0] + 512 * c[2], c[2]);
    row = div_nearest(-512 * c[1] + 320 * c[2], c[2]);
    if (col <= 0 || row <= 0 || col >= IMG_W || row >= IMG_H) return 0;
    pix.col   = col[9:0];
    pix.row   = row[9:0];
    pix.blue  = level_to_byte(bl);
    pix.green = level_to_byte(gl);
    pix.red   = level_to_byte(rl);
    return 1;
  endfunction

  // Track pose writes, queue predictions, compare pixels
  always @(posedge clk) begin
    pixel_t want, got;
    if (rst) begin
      foreach (pose[i]) pose[i] = '0;
      pose[REG_ROT_W] = 32'sd1073741824;
      expected_pixels.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[4:2] <= REG_SHIFT_Z)
        pose[paddr[4:2]] = pwdata;
      if (start && !busy) begin
        if (project_point(world_x, world_y, world_z, red_level, green_level,
                          blue_level, want))
          expected_pixels.push_back(want);
      end
      if (done) begin
        got = {pixel_column, pixel_row, blue_byte, green_byte, red_byte};
        if (expected_pixels.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected pixel col=%0d row=%0d bgr=%0d/%0d/%0d", got.col,
                     got.row, got.blue, got.green, got.red);
        end else begin
          want = expected_pixels.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display({"pixel mismatch: exp col=%0d row=%0d bgr=%0d/%0d/%0d,",
                        " got col=%0d row=%0d bgr=%0d/%0d/%0d"},
                       want.col, want.row, want.blue, want.green, want.red, got.col,
                       got.row, got.blue, got.green, got.red);
          end
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// File: bench/tb_pinhole_point_projector.sv
`timescale 1ns / 100ps

module tb_pinhole_point_projector;
  import ppp_pkg::*;

  localparam logic [2:0] UNUSED_REG = 3'd7;
  localparam int DRAIN_CYCLES = 30;
  localparam logic signed [31:0] DEEP = 32'sd33554432;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] world_x = '0;
  logic signed [31:0] world_y = '0;
  logic signed [31:0] world_z = '0;
  logic [16:0]        red_level = '0;
  logic [16:0]        green_level = '0;
  logic [16:0]        blue_level = '0;
  logic               done;
  logic [9:0]         pixel_column;
  logic [9:0]         pixel_row;
  logic [7:0]         blue_byte;
  logic [7:0]         green_byte;
  logic [7:0]         red_byte;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 errors;
  int                 pending;

  // Stimulus-side copy of the pose, used to aim points at the image
  logic signed [31:0] pose_regs [7];
  bit                 no_gaps;

  pinhole_point_projector dut (.*);

  ppp_checker u_checker (
    .clk, .rst, .start, .busy, .world_x, .world_y, .world_z, .red_level,
    .green_level, .blue_level, .done, .pixel_column, .pixel_row, .blue_byte,
    .green_byte, .red_byte, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .pending
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("pinhole_point_projector test failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic signed [31:0] to_q16(input real m);
    real q;
    q = m * 65536.0;
    if (q > 2147483647.0) q = 2147483647.0;
    if (q < -2147483648.0) q = -2147483648.0;
    return 32'(longint'(q));
  endfunction

  // Hold the transaction until accepted, then idle for a random gap
  task automatic send_point(input logic signed [31:0] px, py, pz,
                            input logic [16:0] rl, gl, bl);
    int gap;
    gap = pick_gap();
    start       <= 1'b1;
    world_x     <= px;
    world_y     <= py;
    world_z     <= pz;
    red_level   <= rl;
    green_level <= gl;
    blue_level  <= bl;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain the pipeline so a register write lands while idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx <= REG_SHIFT_Z) pose_regs[idx] = value;
  endtask

  task automatic random_unit_pose();
    real q [4];
    real n;
    foreach (q[i]) q[i] = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(q[0] * q[0] + q[1] * q[1] + q[2] * q[2] + q[3] * q[3]);
    if (n < 1.0) begin
      q = '{1.0, 0.0, 0.0, 0.0};
      n = 1.0;
    end
    for (int i = 0; i < 4; i++)
      write_reg(3'(i), 32'(longint'(q[i] / n * 1073741824.0)));
    write_reg(REG_SHIFT_X, 32'($urandom_range(0, 2 ** 27)) - 32'd67108864);
    write_reg(REG_SHIFT_Y, 32'($urandom_range(0, 2 ** 27)) - 32'd67108864);
    write_reg(REG_SHIFT_Z, 32'($urandom_range(0, 2 ** 27)) - 32'd67108864);
  endtask

  // Pick a pixel and depth, rotate back into the world frame
  task automatic aimed_point();
    real w, x, y, z, dep;
    real rm [3][3];
    real cam [3];
    real p [3];
    int u, v;
    w = pose_regs[REG_ROT_W] / 1073741824.0;
    x = pose_regs[REG_ROT_X] / 1073741824.0;
    y = pose_regs[REG_ROT_Y] / 1073741824.0;
    z = pose_regs[REG_ROT_Z] / 1073741824.0;
    rm[0][0] = 1 - 2 * (y * y + z * z);
    rm[0][1] = 2 * (x * y - z * w);
    rm[0][2] = 2 * (x * z + y * w);
    rm[1][0] = 2 * (x * y + z * w);
    rm[1][1] = 1 - 2 * (x * x + z * z);
    rm[1][2] = 2 * (y * z - x * w);
    rm[2][0] = 2 * (x * z - y * w);
    rm[2][1] = 2 * (y * z + x * w);
    rm[2][2] = 1 - 2 * (x * x + y * y);
    u = $urandom_range(1, 1023);
    v = $urandom_range(1, 639);
    dep = $urandom_range(1, 200000) / 100.0;
    if ($urandom_range(0, 9) == 0) dep = -dep;
    cam[0] = (512 - u) * dep / 512.0;
    cam[1] = (320 - v) * dep / 512.0;
    cam[2] = dep;
    for (int i = 0; i < 3; i++) begin
      p[i] = pose_regs[REG_SHIFT_X + i] / 65536.0;
      for (int j = 0; j < 3; j++) p[i] += rm[i][j] * cam[j];
    end
    send_point(to_q16(p[0]), to_q16(p[1]), to_q16(p[2]), $urandom_range(0, 65536),
               $urandom_range(0, 65536), $urandom_range(0, 65536));
  endtask

  task automatic random_points(input int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 4) != 0) aimed_point();
      else send_point($urandom, $urandom, $urandom, $urandom_range(0, 131071),
                      $urandom_range(0, 131071), $urandom_range(0, 131071));
    end
  endtask

  initial begin
    foreach (pose_regs[i]) pose_regs[i] = '0;
    pose_regs[REG_ROT_W] = 32'sd1073741824;
    no_gaps = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed points under the reset pose
    send_point(0, 0, 65536, 0, 65536, 131071);
    send_point(0, 0, 0, 1, 2, 3);
    send_point(0, 0, -65536, 32767, 32768, 65535);
    send_point(511 * 65536, 0, DEEP, 65536, 0, 0);
    send_point(512 * 65536, 0, DEEP, 65536, 0, 0);
    send_point(-511 * 65536, 0, DEEP, 0, 65536, 0);
    send_point(-512 * 65536, 0, DEEP, 0, 65536, 0);
    send_point(0, 319 * 65536, DEEP, 0, 0, 65536);
    send_point(0, 320 * 65536, DEEP, 0, 0, 65536);
    send_point(0, -319 * 65536, DEEP, 128, 129, 130);
    send_point(0, -320 * 65536, DEEP, 128, 129, 130);
    send_point(-32768, -32768, DEEP, 100000, 65537, 1);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 131071, 131071, 131071);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 65536, 65536, 65536);
    send_point(0, 0, 32'h8000_0000, 255, 256, 257);
    send_point(0, 0, 1, 65280, 65408, 65535);
    random_points(200);

    // Unit pose with random shift
    drain();
    random_unit_pose();
    random_points(250);

    // Extreme register values, plus an unmapped address
    drain();
    write_reg(REG_ROT_W, -32'sd1073741824);
    write_reg(REG_ROT_X, '0);
    write_reg(REG_ROT_Y, '0);
    write_reg(REG_ROT_Z, '0);
    write_reg(REG_SHIFT_X, 32'h7fff_ffff);
    write_reg(REG_SHIFT_Y, 32'h8000_0000);
    write_reg(REG_SHIFT_Z, 32'h8000_0000);
    write_reg(UNUSED_REG, 32'h1234_5678);
    random_points(200);

    // Half turn about x
    drain();
    write_reg(REG_ROT_W, '0);
    write_reg(REG_ROT_X, 32'sd1073741824);
    write_reg(REG_SHIFT_X, '0);
    write_reg(REG_SHIFT_Y, '0);
    write_reg(REG_SHIFT_Z, '0);
    random_points(250);

    // Non-unit quaternion, entries saturate
    drain();
    write_reg(REG_ROT_W, 32'sd1073741824);
    write_reg(REG_ROT_Y, 32'sd1073741824);
    write_reg(REG_ROT_Z, -32'sd1073741824);
    random_points(250);

    // Back-to-back stretch
    drain();
    random_unit_pose();
    no_gaps = 1'b1;
    random_points(300);
    no_gaps = 1'b0;

    drain();
    random_unit_pose();
    random_points(330);

    drain();
    if (errors == 0 && pending == 0) begin
      $display("pinhole_point_projector test passed");
    end else begin
      $display("pinhole_point_projector test failed");
    end
    $finish;
  end

endmodule
